// File: src/arcpt_pkg.sv
// ----------------------------------------------------------------------------
// Arc point and tangent evaluator package
// Shared constants, pipeline stage types and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package arcpt_pkg;

    localparam int DIV_BITS     = 61;
    localparam int CORDIC_STEPS = 16;

    localparam logic [29:0]        RAD_TO_TURN = 30'd683565276;
    localparam logic signed [32:0] CORDIC_X0   = 33'sd652032874;

    typedef enum logic [2:0] {
        CFG_CENTER_X    = 3'd0,
        CFG_CENTER_Y    = 3'd1,
        CFG_RADIUS      = 3'd2,
        CFG_START_ANGLE = 3'd3,
        CFG_CLOCKWISE   = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic        valid;
        logic        neg;
        logic [30:0] rem;
        logic [60:0] num;
        logic [31:0] quo;
    } div_stage_t;

    typedef struct packed {
        logic               valid;
        logic [1:0]         k;
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [32:0] z;
    } cordic_stage_t;

    function automatic logic [29:0] atan_turn(input logic [4:0] i);
        logic [29:0] a;
        case (i)
            5'd0:  a = 30'd536870912;
            5'd1:  a = 30'd316933406;
            5'd2:  a = 30'd167458907;
            5'd3:  a = 30'd85004756;
            5'd4:  a = 30'd42667331;
            5'd5:  a = 30'd21354465;
            5'd6:  a = 30'd10679838;
            5'd7:  a = 30'd5340245;
            5'd8:  a = 30'd2670163;
            5'd9:  a = 30'd1335087;
            5'd10: a = 30'd667544;
            5'd11: a = 30'd333772;
            5'd12: a = 30'd166886;
            5'd13: a = 30'd83443;
            5'd14: a = 30'd41722;
            5'd15: a = 30'd20861;
            5'd16: a = 30'd10430;
            5'd17: a = 30'd5215;
            5'd18: a = 30'd2608;
            5'd19: a = 30'd1304;
            5'd20: a = 30'd652;
            5'd21: a = 30'd326;
            5'd22: a = 30'd163;
            5'd23: a = 30'd81;
            5'd24: a = 30'd41;
            5'd25: a = 30'd20;
            5'd26: a = 30'd10;
            5'd27: a = 30'd5;
            5'd28: a = 30'd3;
            5'd29: a = 30'd1;
            default: a = 30'd0;
        endcase
        return a;
    endfunction

endpackage

// File: src/arc_point_tangent_eval.sv
// ----------------------------------------------------------------------------
// Arc point and tangent evaluator
// Returns the point and unit tangent on a circular arc for a given arc length.
// ----------------------------------------------------------------------------
// The block takes one transaction per cycle and returns one result per
// transaction, in order, through one multiply stage, a chain of 61 one-bit
// divider cells, one phase stage, 16 CORDIC cells, one scaling multiply stage
// and the output register. The whole pipeline moves together, so it holds
// while a result waits on m_ready. Configuration must only be written while
// no transaction is in flight.
module arc_point_tangent_eval (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic signed [31:0] s_arc_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [31:0] m_point_x,
    output logic signed [31:0] m_point_y,
    output logic signed [15:0] m_tangent_x,
    output logic signed [15:0] m_tangent_y
);

    localparam int NDIV = arcpt_pkg::DIV_BITS;
    localparam int NCOR = arcpt_pkg::CORDIC_STEPS;

    logic [31:0] center_x_reg;
    logic [31:0] center_y_reg;
    logic [30:0] radius_reg;
    logic [15:0] start_angle_reg;
    logic        clockwise_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg    <= '0;
            center_y_reg    <= '0;
            radius_reg      <= 31'd65536;
            start_angle_reg <= '0;
            clockwise_reg   <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                arcpt_pkg::CFG_CENTER_X:    center_x_reg    <= cfg_data;
                arcpt_pkg::CFG_CENTER_Y:    center_y_reg    <= cfg_data;
                arcpt_pkg::CFG_RADIUS:      radius_reg      <= cfg_data[30:0];
                arcpt_pkg::CFG_START_ANGLE: start_angle_reg <= cfg_data[15:0];
                arcpt_pkg::CFG_CLOCKWISE:   clockwise_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic en;
    assign en      = ~m_valid || m_ready;
    assign s_ready = en;

    // Magnitude times the radian-to-turn constant.
    logic        mul_valid_reg;
    logic        mul_neg_reg;
    logic [60:0] mul_prod_reg;
    logic [31:0] s_mag;
    logic [61:0] s_prod;

    always_comb begin
        s_mag  = s_arc_length[31] ? 32'(-s_arc_length) : 32'(s_arc_length);
        s_prod = s_mag * arcpt_pkg::RAD_TO_TURN;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
        end else if (en) begin
            mul_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mul_neg_reg  <= s_arc_length[31];
            mul_prod_reg <= s_prod[60:0];
        end
    end

    arcpt_pkg::div_stage_t div_chain [0:NDIV];

    always_comb begin
        div_chain[0].valid = mul_valid_reg;
        div_chain[0].neg   = mul_neg_reg;
        div_chain[0].rem   = '0;
        div_chain[0].num   = mul_prod_reg;
        div_chain[0].quo   = '0;
    end

    for (genvar g = 0; g < NDIV; g++) begin : g_div
        arcpt_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .radius  (radius_reg),
            .d_in    (div_chain[g]),
            .d_out   (div_chain[g+1])
        );
    end

    // Phase, quadrant and residual angle.
    arcpt_pkg::div_stage_t    div_last;
    arcpt_pkg::cordic_stage_t ph_next;
    arcpt_pkg::cordic_stage_t ph_reg;
    logic                     ph_valid_reg;
    logic [31:0]              inc;
    logic [31:0]              phase;
    logic [31:0]              rounded;
    logic [31:0]              resid;

    always_comb begin
        div_last = div_chain[NDIV];
        inc      = (radius_reg == '0) ? 32'd0 : div_last.quo;
        if (div_last.neg) begin
            inc = 32'd0 - inc;
        end
        phase   = clockwise_reg ? {start_angle_reg, 16'd0} - inc
                                : {start_angle_reg, 16'd0} + inc;
        rounded = phase + 32'h2000_0000;
        resid   = phase - {rounded[31:30], 30'd0};
        ph_next.valid = div_last.valid;
        ph_next.k     = rounded[31:30];
        ph_next.x     = arcpt_pkg::CORDIC_X0;
        ph_next.y     = '0;
        ph_next.z     = $signed({resid[31], resid});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_valid_reg <= 1'b0;
        end else if (en) begin
            ph_valid_reg <= div_last.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ph_reg <= ph_next;
        end
    end

    arcpt_pkg::cordic_stage_t cor_chain [0:NCOR];

    always_comb begin
        cor_chain[0]       = ph_reg;
        cor_chain[0].valid = ph_valid_reg;
    end

    for (genvar g = 0; g < NCOR; g++) begin : g_cor
        arcpt_cordic_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .step    (5'(g)),
            .c_in    (cor_chain[g]),
            .c_out   (cor_chain[g+1])
        );
    end

    // Quadrant mapping and scaling by the radius.
    arcpt_pkg::cordic_stage_t cor_last;
    logic signed [32:0] c_val;
    logic signed [32:0] s_val;
    logic signed [33:0] rad_s;
    logic               sc_valid_reg;
    logic signed [32:0] sc_c_reg;
    logic signed [32:0] sc_s_reg;
    logic signed [66:0] sc_pc_reg;
    logic signed [66:0] sc_ps_reg;

    always_comb begin
        cor_last = cor_chain[NCOR];
        rad_s    = $signed({3'b000, radius_reg});
        case (cor_last.k)
            2'd0: begin
                c_val = cor_last.x;
                s_val = cor_last.y;
            end
            2'd1: begin
                c_val = -cor_last.y;
                s_val = cor_last.x;
            end
            2'd2: begin
                c_val = -cor_last.x;
                s_val = -cor_last.y;
            end
            default: begin
                c_val = cor_last.y;
                s_val = -cor_last.x;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sc_valid_reg <= 1'b0;
        end else if (en) begin
            sc_valid_reg <= cor_last.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sc_c_reg  <= c_val;
            sc_s_reg  <= s_val;
            sc_pc_reg <= rad_s * c_val;
            sc_ps_reg <= rad_s * s_val;
        end
    end

    // Offset by the center, saturation and unit vector rounding.
    logic signed [36:0] off_x;
    logic signed [36:0] off_y;
    logic signed [36:0] sum_x;
    logic signed [36:0] sum_y;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [16:0] tc;
    logic signed [16:0] ts;
    logic signed [15:0] tc_sat;
    logic signed [15:0] ts_sat;
    logic signed [32:0] c_rnd;
    logic signed [32:0] s_rnd;

    logic               out_valid_reg;
    logic signed [31:0] out_px_reg;
    logic signed [31:0] out_py_reg;
    logic signed [15:0] out_tx_reg;
    logic signed [15:0] out_ty_reg;

    always_comb begin
        off_x = 37'((sc_pc_reg + 67'sd536870912) >>> 30);
        off_y = 37'((sc_ps_reg + 67'sd536870912) >>> 30);
        sum_x = off_x + 37'(signed'(center_x_reg));
        sum_y = off_y + 37'(signed'(center_y_reg));
        if (sum_x > 37'sd2147483647) begin
            px = 32'sh7FFF_FFFF;
        end else if (sum_x < -37'sd2147483648) begin
            px = 32'sh8000_0000;
        end else begin
            px = sum_x[31:0];
        end
        if (sum_y > 37'sd2147483647) begin
            py = 32'sh7FFF_FFFF;
        end else if (sum_y < -37'sd2147483648) begin
            py = 32'sh8000_0000;
        end else begin
            py = sum_y[31:0];
        end
        c_rnd = sc_c_reg + 33'sd32768;
        s_rnd = sc_s_reg + 33'sd32768;
        tc    = c_rnd[32:16];
        ts    = s_rnd[32:16];
        if (tc > 17'sd16384) begin
            tc_sat = 16'sd16384;
        end else if (tc < -17'sd16384) begin
            tc_sat = -16'sd16384;
        end else begin
            tc_sat = tc[15:0];
        end
        if (ts > 17'sd16384) begin
            ts_sat = 16'sd16384;
        end else if (ts < -17'sd16384) begin
            ts_sat = -16'sd16384;
        end else begin
            ts_sat = ts[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= sc_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_px_reg <= px;
            out_py_reg <= py;
            out_tx_reg <= clockwise_reg ? ts_sat : -ts_sat;
            out_ty_reg <= clockwise_reg ? -tc_sat : tc_sat;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_point_x   = out_px_reg;
    assign m_point_y   = out_py_reg;
    assign m_tangent_x = out_tx_reg;
    assign m_tangent_y = out_ty_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("Result was dropped while stalled.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        ph_valid_reg |-> (ph_reg.z[32:29] == 4'b0000 || ph_reg.z[32:29] == 4'b1111))
        else $error("Residual angle is outside one octant.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_tangent_x <= 16'sd16384 && m_tangent_x >= -16'sd16384
                     && m_tangent_y <= 16'sd16384 && m_tangent_y >= -16'sd16384))
        else $error("Tangent component exceeds unit range.");

endmodule

// File: src/arcpt_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step: takes one numerator bit, yields one quotient bit.
// ----------------------------------------------------------------------------
module arcpt_div_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic [30:0]          radius,
    input  arcpt_pkg::div_stage_t d_in,
    output arcpt_pkg::div_stage_t d_out
);

    logic                  valid_reg;
    arcpt_pkg::div_stage_t data_reg;
    arcpt_pkg::div_stage_t data_next;
    logic [31:0]           trial;
    logic [32:0]           diff;
    logic                  fit;

    always_comb begin
        trial = {d_in.rem, d_in.num[60]};
        diff  = {1'b0, trial} - {2'b00, radius};
        fit   = ~diff[32];
        data_next       = d_in;
        data_next.rem   = fit ? diff[30:0] : trial[30:0];
        data_next.num   = {d_in.num[59:0], 1'b0};
        data_next.quo   = {d_in.quo[30:0], fit};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= d_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    always_comb begin
        d_out       = data_reg;
        d_out.valid = valid_reg;
    end

endmodule

// File: src/arcpt_cordic_cell.sv
// ----------------------------------------------------------------------------
// CORDIC cell
// One rotation-mode CORDIC micro-rotation toward a zero residual angle.
// ----------------------------------------------------------------------------
module arcpt_cordic_cell (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic [4:0]              step,
    input  arcpt_pkg::cordic_stage_t c_in,
    output arcpt_pkg::cordic_stage_t c_out
);

    logic                     valid_reg;
    arcpt_pkg::cordic_stage_t data_reg;
    arcpt_pkg::cordic_stage_t data_next;
    logic signed [32:0]       dx;
    logic signed [32:0]       dy;
    logic signed [32:0]       ang;

    always_comb begin
        dx  = c_in.y >>> step;
        dy  = c_in.x >>> step;
        ang = $signed({3'b000, arcpt_pkg::atan_turn(step)});
        data_next = c_in;
        if (!c_in.z[32]) begin
            data_next.x = c_in.x - dx;
            data_next.y = c_in.y + dy;
            data_next.z = c_in.z - ang;
        end else begin
            data_next.x = c_in.x + dx;
            data_next.y = c_in.y - dy;
            data_next.z = c_in.z + ang;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= c_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    always_comb begin
        c_out       = data_reg;
        c_out.valid = valid_reg;
    end

endmodule

// File: bench/tb_arc_point_tangent_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Arc point and tangent evaluator testbench
// Drives arc lengths through the valid/ready input channel under several arc
// settings, predicts each point and tangent with a fixed-point CORDIC model and
// checks every result transaction in order, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_arc_point_tangent_eval;

    localparam int LATENCY = 81;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [15:0] tx;
        logic signed [15:0] ty;
    } arc_sample_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = arcpt_pkg::CFG_CENTER_X;
    logic [31:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [31:0] s_arc_length = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_point_x, m_point_y;
    logic signed [15:0] m_tangent_x, m_tangent_y;

    logic signed [31:0] arc_cx = 0, arc_cy = 0;
    logic [30:0] arc_r = 31'd65536;
    logic [15:0] arc_a0 = 0;
    logic arc_cw = 0;

    logic signed [31:0] length_q[$];
    arc_sample_t expected_q[$];
    int errors = 0;
    bit calm = 0;
    int s_idle = 0, m_idle = 0;

    arc_point_tangent_eval u_top (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint unit14(longint v);
        longint t;
        t = fshr(v + 32768, 16);
        if (t > 16384) t = 16384;
        if (t < -16384) t = -16384;
        return t;
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic arc_sample_t predict_arc_point(logic signed [31:0] len);
        logic [31:0] inc, phase, resid;
        logic [63:0] mag;
        logic [1:0] k;
        longint x, y, z, dx, dy, c, sn, tc, ts;
        arc_sample_t r;
        mag = len[31] ? 64'(-{1'b0, len}) & 64'hFFFF_FFFF : 64'(len);
        inc = 0;
        if (arc_r != 0) inc = 32'((mag * 64'd683565276) / 64'(arc_r));
        if (len[31]) inc = -inc;
        phase = {arc_a0, 16'h0};
        phase = arc_cw ? phase - inc : phase + inc;
        k = 2'((phase + 32'h2000_0000) >> 30);
        resid = phase - {k, 30'h0};
        z = longint'(signed'(resid));
        x = 652032874;
        y = 0;
        for (int i = 0; i < arcpt_pkg::CORDIC_STEPS; i++) begin
            dx = fshr(y, i);
            dy = fshr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(arcpt_pkg::atan_turn(5'(i)));
            end else begin
                x += dx; y -= dy; z += longint'(arcpt_pkg::atan_turn(5'(i)));
            end
        end
        case (k)
            2'd0: begin c = x; sn = y; end
            2'd1: begin c = -y; sn = x; end
            2'd2: begin c = -x; sn = -y; end
            default: begin c = y; sn = -x; end
        endcase
        r.px = 32'(sat32(longint'(arc_cx) + fshr(longint'(arc_r) * c + 64'h2000_0000, 30)));
        r.py = 32'(sat32(longint'(arc_cy) + fshr(longint'(arc_r) * sn + 64'h2000_0000, 30)));
        tc = unit14(c);
        ts = unit14(sn);
        r.tx = 16'(arc_cw ? ts : -ts);
        r.ty = 16'(arc_cw ? -tc : tc);
        return r;
    endfunction

    task automatic write_reg(arcpt_pkg::cfg_index_t idx, logic [31:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            arcpt_pkg::CFG_CENTER_X: arc_cx = val;
            arcpt_pkg::CFG_CENTER_Y: arc_cy = val;
            arcpt_pkg::CFG_RADIUS: arc_r = val[30:0];
            arcpt_pkg::CFG_START_ANGLE: arc_a0 = val[15:0];
            arcpt_pkg::CFG_CLOCKWISE: arc_cw = val[0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (length_q.size() != 0 || expected_q.size() != 0 || s_valid) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    task automatic setup_arc(logic [31:0] cx, logic [31:0] cy, logic [31:0] r,
                             logic [31:0] a0, logic [31:0] cw);
        drain();
        write_reg(arcpt_pkg::CFG_CENTER_X, cx);
        write_reg(arcpt_pkg::CFG_CENTER_Y, cy);
        write_reg(arcpt_pkg::CFG_RADIUS, r);
        write_reg(arcpt_pkg::CFG_START_ANGLE, a0);
        write_reg(arcpt_pkg::CFG_CLOCKWISE, cw);
    endtask

    function automatic logic [31:0] rand_length();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
            2: return 32'($signed($urandom_range(0, 32'h0640_0000)) - 32'sh0320_0000);
            default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 255)
                                                 : 32'h8000_0000 + $urandom_range(0, 255);
        endcase
    endfunction

    function automatic logic [31:0] rand_radius();
        case ($urandom_range(0, 3))
            0: return $urandom_range(1, 255);
            1: return $urandom_range(32'h0000_4000, 32'h0064_0000);
            2: return $urandom & 32'h7FFF_FFFF;
            default: return 32'h7FFF_FFFF - $urandom_range(0, 15);
        endcase
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_idle > 0) begin
                s_idle <= s_idle - 1;
                s_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                s_idle <= $urandom_range(0, 7);
                s_valid <= 1'b0;
            end else if (length_q.size() != 0) begin
                s_arc_length <= length_q[0];
                expected_q.push_back(predict_arc_point(length_q[0]));
                void'(length_q.pop_front());
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result %h %h %h %h", $time,
                             m_point_x, m_point_y, m_tangent_x, m_tangent_y);
                    errors++;
                end else begin
                    arc_sample_t e;
                    e = expected_q.pop_front();
                    if (e.px !== m_point_x) begin
                        $display("%0t: point_x expected %0d actual %0d", $time, e.px, m_point_x);
                        errors++;
                    end
                    if (e.py !== m_point_y) begin
                        $display("%0t: point_y expected %0d actual %0d", $time, e.py, m_point_y);
                        errors++;
                    end
                    if (e.tx !== m_tangent_x) begin
                        $display("%0t: tangent_x expected %0d actual %0d", $time, e.tx,
                                 m_tangent_x);
                        errors++;
                    end
                    if (e.ty !== m_tangent_y) begin
                        $display("%0t: tangent_y expected %0d actual %0d", $time, e.ty,
                                 m_tangent_y);
                        errors++;
                    end
                end
            end
            if (m_idle > 0) begin
                m_idle <= m_idle - 1;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                m_idle <= $urandom_range(0, 7);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        logic [31:0] directed[$];
        directed = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h0001_0000, 32'hFFFF_0000, 32'h0006_487F, 32'h0003_243F,
                     32'h0001_921F, 32'h0004_B65F, 32'h5555_5555, 32'hAAAA_AAAA};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (directed[i]) length_q.push_back(directed[i]);
        setup_arc(32'h7FFF_0000, 32'h8000_1000, 32'h7FFF_FFFF, 16'hFFFF, 1);
        foreach (directed[i]) length_q.push_back(directed[i]);
        setup_arc(32'h0, 32'h0, 32'h0, 16'h4000, 0);
        length_q.push_back(32'h1234_5678);
        length_q.push_back(32'h8000_0000);
        setup_arc(32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 16'h8000, 1);
        length_q.push_back(32'h0001_0000);
        length_q.push_back(32'h7FFF_FFFF);
        for (int p = 0; p < 12; p++) begin
            setup_arc($urandom, $urandom, rand_radius(), $urandom, $urandom);
            if (p == 11) calm = 1;
            for (int n = 0; n < 105; n++) length_q.push_back(rand_length());
        end
        drain();
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
